FILE: rtl/pdcl_pkg.sv
`default_nettype none

package pdcl_pkg;

    // Longest code the design supports; symbols beyond eight have no pattern bit.
    localparam int MAX_CODE_LEN = 8;
    localparam int CODE_CAP     = (MAX_CODE_LEN > 8) ? 8 : MAX_CODE_LEN;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    // Register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_CODE_PATTERN = 3'd0,
        REG_SYMBOL_COUNT = 3'd1,
        REG_BOUNCE       = 3'd2,
        REG_SHORT_MAX    = 3'd3,
        REG_IDLE_TIMEOUT = 3'd4,
        REG_MAX_FAILURES = 3'd5
    } reg_idx_t;

    // Reset values of the registers
    localparam logic [7:0]  RST_CODE_PATTERN = 8'd240;
    localparam logic [3:0]  RST_SYMBOL_COUNT = 4'd8;
    localparam logic [15:0] RST_BOUNCE       = 16'd20;
    localparam logic [15:0] RST_SHORT_MAX    = 16'd500;
    localparam logic [15:0] RST_IDLE_TIMEOUT = 16'd3000;
    localparam logic [3:0]  RST_MAX_FAILURES = 4'd3;

    // Event codes reported with each result
    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_OK      = 3'd1,
        EV_ACCEPT  = 3'd2,
        EV_WRONG   = 3'd3,
        EV_LOCK    = 3'd4,
        EV_TIMEOUT = 3'd5
    } ev_t;

    typedef struct packed {
        logic [7:0]  code_pattern;
        logic [3:0]  symbol_count;
        logic [15:0] bounce_ticks;
        logic [15:0] short_max_ticks;
        logic [15:0] idle_timeout_ticks;
        logic [3:0]  max_failures;
    } cfg_t;

    typedef struct packed {
        ev_t         ev;
        logic [2:0]  position;
        logic [3:0]  failure_count;
    } res_t;

endpackage

`default_nettype wire

FILE: rtl/pdcl_cfg_regs.sv
`default_nettype none

module pdcl_cfg_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [pdcl_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [pdcl_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [pdcl_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                 pready,
    output pdcl_pkg::cfg_t                       cfg
);

    pdcl_pkg::cfg_t   cfg_reg;
    pdcl_pkg::reg_idx_t idx;
    logic             wr_en;

    assign idx    = pdcl_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Write the addressed register on the access beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.code_pattern       <= pdcl_pkg::RST_CODE_PATTERN;
            cfg_reg.symbol_count       <= pdcl_pkg::RST_SYMBOL_COUNT;
            cfg_reg.bounce_ticks       <= pdcl_pkg::RST_BOUNCE;
            cfg_reg.short_max_ticks    <= pdcl_pkg::RST_SHORT_MAX;
            cfg_reg.idle_timeout_ticks <= pdcl_pkg::RST_IDLE_TIMEOUT;
            cfg_reg.max_failures       <= pdcl_pkg::RST_MAX_FAILURES;
        end
        else if (wr_en)
        begin
            case (idx)
                pdcl_pkg::REG_CODE_PATTERN: cfg_reg.code_pattern       <= pwdata[7:0];
                pdcl_pkg::REG_SYMBOL_COUNT: cfg_reg.symbol_count       <= pwdata[3:0];
                pdcl_pkg::REG_BOUNCE:       cfg_reg.bounce_ticks       <= pwdata[15:0];
                pdcl_pkg::REG_SHORT_MAX:    cfg_reg.short_max_ticks    <= pwdata[15:0];
                pdcl_pkg::REG_IDLE_TIMEOUT: cfg_reg.idle_timeout_ticks <= pwdata[15:0];
                pdcl_pkg::REG_MAX_FAILURES: cfg_reg.max_failures       <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // Return the addressed register, zero-extended
    always_comb
    begin
        case (idx)
            pdcl_pkg::REG_CODE_PATTERN: prdata = {24'd0, cfg_reg.code_pattern};
            pdcl_pkg::REG_SYMBOL_COUNT: prdata = {28'd0, cfg_reg.symbol_count};
            pdcl_pkg::REG_BOUNCE:       prdata = {16'd0, cfg_reg.bounce_ticks};
            pdcl_pkg::REG_SHORT_MAX:    prdata = {16'd0, cfg_reg.short_max_ticks};
            pdcl_pkg::REG_IDLE_TIMEOUT: prdata = {16'd0, cfg_reg.idle_timeout_ticks};
            pdcl_pkg::REG_MAX_FAILURES: prdata = {28'd0, cfg_reg.max_failures};
            default:                    prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/pdcl_core.sv
`default_nettype none

module pdcl_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           fire,
    input  wire logic           pressed,
    input  pdcl_pkg::cfg_t      cfg,
    output pdcl_pkg::res_t      res
);

    logic        active_reg, active_next;
    logic [15:0] press_reg,  press_next;
    logic [2:0]  pos_reg,    pos_next;
    logic [3:0]  wrong_reg,  wrong_next;
    logic [15:0] idle_reg,   idle_next;

    logic [15:0] press_inc;
    logic [15:0] idle_inc;
    logic        timeout;
    logic        sym;
    logic        want;
    logic [3:0]  eff_len;
    logic [3:0]  lim;
    logic [3:0]  pos_plus;
    logic [3:0]  wrong_inc;
    pdcl_pkg::ev_t ev;

    // Advance the tick counters, saturating at all ones
    assign press_inc = (active_reg && press_reg != 16'hFFFF) ? press_reg + 16'd1 : press_reg;
    assign idle_inc  = (idle_reg != 16'hFFFF) ? idle_reg + 16'd1 : idle_reg;
    assign timeout   = (pos_reg != 3'd0) && (idle_inc >= cfg.idle_timeout_ticks);

    // Clamp code length and failure limit to usable values
    always_comb
    begin
        eff_len = cfg.symbol_count;
        if (eff_len == 4'd0)
        begin
            eff_len = 4'd1;
        end
        if (eff_len > 4'(pdcl_pkg::CODE_CAP))
        begin
            eff_len = 4'(pdcl_pkg::CODE_CAP);
        end
    end

    assign lim       = (cfg.max_failures == 4'd0) ? 4'd1 : cfg.max_failures;
    assign sym       = press_inc > cfg.short_max_ticks;
    assign want      = cfg.code_pattern[pos_reg];
    assign pos_plus  = {1'b0, pos_reg} + 4'd1;
    assign wrong_inc = wrong_reg + 4'd1;

    // Work out one tick
    always_comb
    begin
        active_next = active_reg;
        press_next  = press_inc;
        pos_next    = pos_reg;
        wrong_next  = wrong_reg;
        idle_next   = idle_inc;
        ev          = pdcl_pkg::EV_NONE;

        if (timeout)
        begin
            pos_next   = 3'd0;
            wrong_next = 4'd0;
            idle_next  = 16'd0;
            ev         = pdcl_pkg::EV_TIMEOUT;
        end
        else if (pressed)
        begin
            if (!active_reg)
            begin
                active_next = 1'b1;
                press_next  = 16'd0;
            end
        end
        else if (active_reg)
        begin
            active_next = 1'b0;
            if (press_inc > cfg.bounce_ticks)
            begin
                idle_next = 16'd0;
                if (sym == want)
                begin
                    if (pos_plus >= eff_len)
                    begin
                        pos_next   = 3'd0;
                        wrong_next = 4'd0;
                        ev         = pdcl_pkg::EV_ACCEPT;
                    end
                    else
                    begin
                        pos_next = pos_plus[2:0];
                        ev       = pdcl_pkg::EV_OK;
                    end
                end
                else
                begin
                    pos_next = 3'd0;
                    if (wrong_inc >= lim)
                    begin
                        wrong_next = 4'd0;
                        ev         = pdcl_pkg::EV_LOCK;
                    end
                    else
                    begin
                        wrong_next = wrong_inc;
                        ev         = pdcl_pkg::EV_WRONG;
                    end
                end
            end
        end

        res.ev            = ev;
        res.position      = pos_next;
        res.failure_count = wrong_next;
    end

    // Hold the lock state, update on each fired tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            press_reg  <= 16'd0;
            pos_reg    <= 3'd0;
            wrong_reg  <= 4'd0;
            idle_reg   <= 16'd0;
        end
        else if (fire)
        begin
            active_reg <= active_next;
            press_reg  <= press_next;
            pos_reg    <= pos_next;
            wrong_reg  <= wrong_next;
            idle_reg   <= idle_next;
        end
    end

`ifndef SYNTH
    a_timeout_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && timeout |=> pos_reg == 3'd0 && wrong_reg == 4'd0 && idle_reg == 16'd0)
        else $error("timeout did not clear entry state");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(pos_reg) && $stable(wrong_reg) && $stable(idle_reg)
                  && $stable(active_reg) && $stable(press_reg))
        else $error("state moved without a tick");

    a_lock_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (ev == pdcl_pkg::EV_LOCK || ev == pdcl_pkg::EV_ACCEPT)
        |=> wrong_reg == 4'd0 && pos_reg == 3'd0)
        else $error("lockout or accept left entry state behind");

    a_press_ends: assert property (@(posedge clk) disable iff (!rst_n)
        fire && ev != pdcl_pkg::EV_NONE && ev != pdcl_pkg::EV_TIMEOUT |=> !active_reg)
        else $error("judged press still active");
`endif

endmodule

`default_nettype wire

FILE: rtl/press_duration_code_lock.sv
`default_nettype none

// Channel  Direction  Handshake             Payload
// in       sink       in_valid / in_stall   button_pressed
// out      source     out_valid / out_stall event_res, position, failure_count
// cfg      APB slave  psel/penable/pready   paddr, pwdata, prdata (six registers)
//
// One tick sample per cycle while out is not stalled: a sample waits in the
// input register, then the step logic updates the lock state and loads the
// result register. The input register refills in the same cycle it drains, so
// throughput is one beat per cycle. A stall on out holds the result register
// and, through it, the input register. Reset clears the valid flags and the
// lock state; registers return to their documented defaults.

module press_duration_code_lock (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic                            button_pressed,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic      [2:0]                      event_res,
    output logic      [2:0]                      position,
    output logic      [3:0]                      failure_count,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [pdcl_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [pdcl_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [pdcl_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                 pready
);

    pdcl_pkg::cfg_t cfg;
    pdcl_pkg::res_t res;

    logic           in_valid_reg;
    logic           sample_reg;
    logic           out_valid_reg;
    pdcl_pkg::res_t res_reg;
    logic           fire;
    logic           in_take;

    // Step whenever a sample is held and the result slot is free or draining
    assign fire     = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !fire;
    assign in_take  = in_valid && !in_stall;

    pdcl_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pdcl_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .pressed (sample_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            sample_reg <= button_pressed;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign event_res     = res_reg.ev;
    assign position      = res_reg.position;
    assign failure_count = res_reg.failure_count;

`ifndef SYNTH
    a_accept_resets: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res == pdcl_pkg::EV_ACCEPT |-> position == 3'd0
                                                        && failure_count == 4'd0)
        else $error("accepted code left position or failures set");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> !fire)
        else $error("result overwritten while stalled");

    a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid)
        else $error("tick produced no result");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/press_duration_code_lock_tb.sv
module press_duration_code_lock_tb;

    localparam int LEN_CAP        = (pdcl_pkg::MAX_CODE_LEN > 8) ? 8
                                                                 : pdcl_pkg::MAX_CODE_LEN;
    localparam int TOTAL_TICKS    = 1950;
    localparam int LONG_HOLD      = 150;
    localparam int DRAIN_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    logic                            button_pressed;
    logic                            out_valid;
    logic                            out_stall;
    logic [2:0]                      event_res;
    logic [2:0]                      position;
    logic [3:0]                      failure_count;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [pdcl_pkg::CFG_ADDR_W-1:0] paddr;
    logic [pdcl_pkg::CFG_DATA_W-1:0] pwdata;
    logic [pdcl_pkg::CFG_DATA_W-1:0] prdata;
    logic                            pready;

    // Lock state mirrored on the bench side
    pdcl_pkg::cfg_t lock_cfg;
    bit             held;
    bit [15:0]      held_ticks;
    bit [2:0]       code_pos;
    bit [3:0]       misses;
    bit [15:0]      quiet_ticks;
    pdcl_pkg::res_t lock_reports[$];

    bit          in_gaps  = 1'b1;
    bit          out_gaps = 1'b1;
    bit          hold_req = 1'b0;
    int          items_sent;
    int          reg_writes;
    int          mismatches;
    int          n_accepts;
    int          n_locks;
    int          n_timeouts;

    press_duration_code_lock i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .button_pressed (button_pressed),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .event_res      (event_res),
        .position       (position),
        .failure_count  (failure_count),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Advance the mirrored lock by one tick and return the report it gives
    function automatic pdcl_pkg::res_t next_lock_report(bit pressed);
        pdcl_pkg::res_t rep;
        bit   sym;
        int   lim;
        int   len;
        rep.ev = pdcl_pkg::EV_NONE;
        if (held && held_ticks != 16'hFFFF)
            held_ticks++;
        if (quiet_ticks != 16'hFFFF)
            quiet_ticks++;
        if (code_pos != 0 && quiet_ticks >= lock_cfg.idle_timeout_ticks)
        begin
            // abandon the partial entry; the button sample is ignored
            code_pos    = '0;
            misses      = '0;
            quiet_ticks = '0;
            rep.ev      = pdcl_pkg::EV_TIMEOUT;
            n_timeouts++;
        end
        else if (pressed)
        begin
            if (!held)
            begin
                held       = 1'b1;
                held_ticks = '0;
            end
        end
        else if (held)
        begin
            held = 1'b0;
            // a release within the bounce time drops the press silently
            if (held_ticks > lock_cfg.bounce_ticks)
            begin
                sym = held_ticks > lock_cfg.short_max_ticks;
                lim = (lock_cfg.max_failures == 0) ? 1 : int'(lock_cfg.max_failures);
                len = (lock_cfg.symbol_count == 0) ? 1 : int'(lock_cfg.symbol_count);
                if (len > LEN_CAP)
                    len = LEN_CAP;
                quiet_ticks = '0;
                if (sym == lock_cfg.code_pattern[code_pos])
                begin
                    // a position left beyond a shortened code completes it
                    if (int'(code_pos) + 1 >= len)
                    begin
                        code_pos = '0;
                        misses   = '0;
                        rep.ev   = pdcl_pkg::EV_ACCEPT;
                        n_accepts++;
                    end
                    else
                    begin
                        code_pos++;
                        rep.ev = pdcl_pkg::EV_OK;
                    end
                end
                else
                begin
                    code_pos = '0;
                    misses++;
                    if (int'(misses) >= lim)
                    begin
                        misses = '0;
                        rep.ev = pdcl_pkg::EV_LOCK;
                        n_locks++;
                    end
                    else
                        rep.ev = pdcl_pkg::EV_WRONG;
                end
            end
        end
        rep.position      = code_pos;
        rep.failure_count = misses;
        return rep;
    endfunction

    // Queue a report for every input beat
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            lock_reports.push_back(next_lock_report(button_pressed));
    end

    // Compare every output beat with the oldest queued report
    always @(posedge clk)
    begin : check_reports
        pdcl_pkg::res_t due;
        if (rst_n && out_valid && !out_stall)
        begin
            if (lock_reports.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected beat ev=%0d pos=%0d fails=%0d",
                         $time, event_res, position, failure_count);
            end
            else
            begin
                due = lock_reports.pop_front();
                if (event_res !== due.ev || position !== due.position ||
                    failure_count !== due.failure_count)
                begin
                    mismatches++;
                    $display("%0t: mismatch ev exp %0d got %0d, pos exp %0d got %0d,",
                             $time, due.ev, event_res, due.position, position,
                             " fails exp %0d got %0d", due.failure_count, failure_count);
                end
            end
        end
    end

    // Stall the output in random bursts, or for one long hold when asked
    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left == 0)
            begin
                if (hold_req)
                begin
                    stall_left = LONG_HOLD;
                    hold_req   = 1'b0;
                end
                else if (out_gaps && $urandom_range(0, 7) == 0)
                    stall_left = $urandom_range(1, 10);
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // End the run when no beat moves for too long
    initial
    begin : watchdog
        int stuck_cycles;
        stuck_cycles = 0;
        while (stuck_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("press_duration_code_lock test failed");
        $finish;
    end

    // Offer one tick sample, with an occasional idle burst first
    task automatic send_tick(bit level);
        int gap;
        if (in_gaps && $urandom_range(0, 9) == 0)
        begin
            gap = $urandom_range(1, 10);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid       <= 1'b1;
        button_pressed <= level;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // Hold the button for dur ticks, then release it
    task automatic press(int unsigned dur);
        repeat (dur) send_tick(1'b1);
        send_tick(1'b0);
    endtask

    task automatic pause(int unsigned ticks);
        repeat (ticks) send_tick(1'b0);
    endtask

    // Drop valid and wait until every queued report has come out
    task automatic settle();
        in_valid <= 1'b0;
        while (lock_reports.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(pdcl_pkg::reg_idx_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            pdcl_pkg::REG_CODE_PATTERN: lock_cfg.code_pattern       = value[7:0];
            pdcl_pkg::REG_SYMBOL_COUNT: lock_cfg.symbol_count       = value[3:0];
            pdcl_pkg::REG_BOUNCE:       lock_cfg.bounce_ticks       = value[15:0];
            pdcl_pkg::REG_SHORT_MAX:    lock_cfg.short_max_ticks    = value[15:0];
            pdcl_pkg::REG_IDLE_TIMEOUT: lock_cfg.idle_timeout_ticks = value[15:0];
            pdcl_pkg::REG_MAX_FAILURES: lock_cfg.max_failures       = value[3:0];
            default: ;
        endcase
        reg_writes++;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // Reset values: a press one tick past the bounce time is a short symbol
    task automatic test_reset_values();
        press(21);
    endtask

    task automatic test_symbols();
        settle();
        write_reg(pdcl_pkg::REG_CODE_PATTERN, 8'b0000_0101);
        write_reg(pdcl_pkg::REG_SYMBOL_COUNT, 3);
        write_reg(pdcl_pkg::REG_BOUNCE, 1);
        write_reg(pdcl_pkg::REG_SHORT_MAX, 2);
        write_reg(pdcl_pkg::REG_IDLE_TIMEOUT, 6);
        write_reg(pdcl_pkg::REG_MAX_FAILURES, 2);
        // the entry left open by the previous test times out
        pause(6);
        press(1);
        // long, short, long completes the code
        press(3);
        press(2);
        press(3);
        // two wrong symbols raise the lockout
        press(2);
        press(2);
    endtask

    task automatic test_length_limits();
        settle();
        // a zero length acts as a one-symbol code
        write_reg(pdcl_pkg::REG_CODE_PATTERN, 8'h81);
        write_reg(pdcl_pkg::REG_SYMBOL_COUNT, 0);
        write_reg(pdcl_pkg::REG_IDLE_TIMEOUT, 16'hFFFF);
        press(3);
        settle();
        write_reg(pdcl_pkg::REG_CODE_PATTERN, 8'hFF);
        write_reg(pdcl_pkg::REG_SYMBOL_COUNT, 15);
        repeat (5) press(3);
        // shorten the code below the current position
        settle();
        write_reg(pdcl_pkg::REG_SYMBOL_COUNT, 2);
        press(3);
    endtask

    task automatic test_failure_limits();
        settle();
        // a zero limit locks on the first wrong symbol
        write_reg(pdcl_pkg::REG_MAX_FAILURES, 0);
        press(2);
    endtask

    task automatic test_timing_limits();
        settle();
        write_reg(pdcl_pkg::REG_BOUNCE, 0);
        write_reg(pdcl_pkg::REG_SHORT_MAX, 1);
        write_reg(pdcl_pkg::REG_IDLE_TIMEOUT, 1);
        write_reg(pdcl_pkg::REG_MAX_FAILURES, 15);
        press(1);
        press(2);
        pause(1);
        settle();
        write_reg(pdcl_pkg::REG_BOUNCE, 16'hFFFF);
        write_reg(pdcl_pkg::REG_SHORT_MAX, 16'hFFFF);
        press(3);
    endtask

    // Hold the output long while the input keeps offering beats
    task automatic test_backpressure();
        settle();
        write_reg(pdcl_pkg::REG_CODE_PATTERN, $urandom_range(0, 255));
        write_reg(pdcl_pkg::REG_SYMBOL_COUNT, 4);
        write_reg(pdcl_pkg::REG_BOUNCE, 1);
        write_reg(pdcl_pkg::REG_SHORT_MAX, 3);
        write_reg(pdcl_pkg::REG_IDLE_TIMEOUT, 20);
        write_reg(pdcl_pkg::REG_MAX_FAILURES, 3);
        in_gaps  = 1'b0;
        hold_req = 1'b1;
        repeat (40) send_tick($urandom_range(0, 1));
        in_gaps = 1'b1;
    endtask

    task automatic test_random_entry();
        int unsigned phase_end;
        int          b;
        int          s;
        int          t;
        int          hi;
        int          pick;
        bit          sym;
        while (items_sent < TOTAL_TICKS)
        begin
            // no idling in the closing stretch
            if (items_sent + 300 >= TOTAL_TICKS)
            begin
                in_gaps  = 1'b0;
                out_gaps = 1'b0;
            end
            settle();
            b  = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4);
            s  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, b + 1)
                                              : b + $urandom_range(1, 5);
            t  = ($urandom_range(0, 5) == 0) ? 65535 : $urandom_range(6, 60);
            hi = (s > b) ? s : b;
            write_reg(pdcl_pkg::REG_CODE_PATTERN, $urandom_range(0, 255));
            write_reg(pdcl_pkg::REG_SYMBOL_COUNT,
                      ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15)
                                                  : $urandom_range(1, 8));
            write_reg(pdcl_pkg::REG_BOUNCE, b);
            write_reg(pdcl_pkg::REG_SHORT_MAX, s);
            write_reg(pdcl_pkg::REG_IDLE_TIMEOUT, t);
            write_reg(pdcl_pkg::REG_MAX_FAILURES,
                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                  : $urandom_range(1, 4));
            phase_end = items_sent + $urandom_range(120, 200);
            while (items_sent < phase_end && items_sent < TOTAL_TICKS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                begin
                    // mostly the symbol the lock wants next
                    sym = lock_cfg.code_pattern[code_pos] ^ ($urandom_range(0, 4) == 0);
                    if (!sym && s > b)
                        press($urandom_range(b + 1, s));
                    else
                        press($urandom_range(hi + 1, hi + 4));
                    pause($urandom_range(0, 3));
                end
                else if (pick < 80)
                    press($urandom_range(0, b));
                else if (pick < 88)
                    pause($urandom_range(1, (t < 100) ? t + 5 : 40));
                else
                    repeat ($urandom_range(1, 8)) send_tick($urandom_range(0, 1));
            end
        end
    endtask

    initial
    begin : run
        in_valid       = 1'b0;
        button_pressed = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        rst_n          = 1'b0;
        lock_cfg.code_pattern       = pdcl_pkg::RST_CODE_PATTERN;
        lock_cfg.symbol_count       = pdcl_pkg::RST_SYMBOL_COUNT;
        lock_cfg.bounce_ticks       = pdcl_pkg::RST_BOUNCE;
        lock_cfg.short_max_ticks    = pdcl_pkg::RST_SHORT_MAX;
        lock_cfg.idle_timeout_ticks = pdcl_pkg::RST_IDLE_TIMEOUT;
        lock_cfg.max_failures       = pdcl_pkg::RST_MAX_FAILURES;
        held        = 1'b0;
        held_ticks  = '0;
        code_pos    = '0;
        misses      = '0;
        quiet_ticks = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        test_reset_values();
        test_symbols();
        test_length_limits();
        test_failure_limits();
        test_timing_limits();
        test_backpressure();
        test_random_entry();
        settle();

        $display("Ran %0d ticks through %0d register writes, with a %0d-cycle hold-off.",
                 items_sent, reg_writes, LONG_HOLD);
        $display("Reports seen: %0d codes accepted, %0d lockouts, %0d timeouts.",
                 n_accepts, n_locks, n_timeouts);
        if (mismatches == 0)
            $display("press_duration_code_lock test passed");
        else
            $display("press_duration_code_lock test failed");
        $finish;
    end

endmodule
